@@ rtl/apl_pkg.sv @@
// Shared constants and types for the audio peak limiter.
package apl_pkg;

   localparam int MUL_W = 32;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 16;
   localparam int GAIN_W = 15;

   typedef logic [MUL_W-1:0]   mul_operand_type;
   typedef logic [2*MUL_W-1:0] mul_product_type;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE     = 4'd3;

endpackage

@@ rtl/apl_req_if.sv @@
// Sample request channel.
interface apl_req_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/apl_rsp_if.sv @@
// Limited sample response channel.
interface apl_rsp_if
   import apl_pkg::*;
#(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic [GAIN_W-1:0]              gain;
   modport source (output valid, output sample_out, output gain, input ready);
   modport sink   (input valid, input sample_out, input gain, output ready);
endinterface

@@ rtl/apl_csr_if.sv @@
// Register write channel.
interface apl_csr_if
   import apl_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/apl_mul.sv @@
// Shared unsigned multiplier used by every multiplying step.
module apl_mul
   import apl_pkg::*;
(
   input  mul_operand_type a,
   input  mul_operand_type b,
   output mul_product_type p
);
   assign p = mul_product_type'(a) * mul_product_type'(b);
endmodule

@@ rtl/audio_peak_limiter.sv @@
// Top level of the envelope-following peak limiter.
//
//  channel   dir  payload                  handshake
//  req_chan  in   sample_in                valid/ready
//  rsp_chan  out  sample_out, gain         valid/ready, output register
//  csr_chan  in   index, wdata             valid/ready, ready always high
//
// One 32x32 multiplier is shared by all multiplying steps under a sequencer.
// A unity-gain request updates the envelope, checks it and goes to output.
// A limited request runs two log2 passes of LOG_EXP_STEPS squarings, then as
// many exp2 steps, each a load and one isqrt bit per cycle for 31 bits.
// Synchronous reset clears envelope and control, loads CSR defaults. A new
// request is taken while a response waits; the next result waits for it.
module audio_peak_limiter
   import apl_pkg::*;
#(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int LOG_EXP_STEPS = 16
) (
   input  logic      clock,
   input  logic      reset,
   apl_req_if.sink   req_chan,
   apl_rsp_if.source rsp_chan,
   apl_csr_if.sink   csr_chan
);

   localparam int SW  = SAMPLE_WIDTH;
   localparam int F   = LOG_EXP_STEPS;
   localparam int EW  = SW - 1;
   localparam int VW  = (EW > GAIN_W) ? EW : GAIN_W;
   localparam int AW  = EW + 18;
   localparam int LW  = 5 + F;
   localparam int XW  = 16 + LW;
   localparam int NW  = XW - F - 12;
   localparam logic [EW-1:0] SMAX = {EW{1'b1}};

   typedef enum logic [3:0] {
      ST_IDLE, ST_ENV_A, ST_ENV_B, ST_CHECK, ST_LOG_INIT, ST_LOG_SQ,
      ST_EXPO, ST_SQ_INIT, ST_SQ_STEP, ST_SHIFT, ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic signed [SW-1:0]  s_ff, s_in;
   logic [EW-1:0]         env_ff, env_in;
   logic [EW-1:0]         rise_ff, rise_in;
   logic [AW-1:0]         acc_ff, acc_in;
   logic                  sel_ff, sel_in;
   logic [4:0]            p_ff, p_in;
   logic [30:0]           m_ff, m_in;
   logic [F-1:0]          frac_ff, frac_in;
   logic [4:0]            cnt_ff, cnt_in;
   logic [LW-1:0]         lga_ff, lga_in;
   logic [LW-1:0]         lgb_ff, lgb_in;
   logic [XW-1:0]         e_ff, e_in;
   logic [30:0]           y_ff, y_in;
   logic [60:0]           v_ff, v_in;
   logic [30:0]           r_ff, r_in;
   logic [4:0]            j_ff, j_in;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]  out_s_ff, out_s_in;
   logic [GAIN_W-1:0]     out_g_ff, out_g_in;
   logic [14:0]           thr_ff;
   logic [15:0]           att_ff, rel_ff, slope_ff;

   mul_operand_type       mul_a, mul_b;
   mul_product_type       prod;

   logic [SW-1:0]         abs_s;
   logic [EW-1:0]         mag;
   logic [14:0]           thr_eff;
   logic [VW-1:0]         lv;
   logic [4:0]            lead;
   logic [AW-1:0]         sum;
   logic [EW+1:0]         env_new;
   logic [31:0]           sq;
   logic [F-1:0]          frac_new;
   logic [30:0]           trial;
   logic [NW-1:0]         n_sh;
   logic [30:0]           y_sh;
   logic [16:0]           g_r;
   logic signed [SW+15:0] pm, t;
   logic signed [SW:0]    q;

   apl_mul u_mul (.a(mul_a), .b(mul_b), .p(prod));

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = out_s_ff;
   assign rsp_chan.gain       = out_g_ff;

   assign abs_s   = s_ff[SW-1] ? (~s_ff + 1'b1) : s_ff;
   assign mag     = (abs_s > SW'(SMAX)) ? SMAX : abs_s[EW-1:0];
   assign thr_eff = (thr_ff == '0) ? 15'd1 : thr_ff;
   assign lv      = sel_ff ? VW'(thr_eff) : VW'(env_ff);

   always_comb begin
      lead = '0;
      for (int i = 0; i < VW; i++) begin
         if (lv[i]) lead = 5'(i);
      end
   end

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      env_in       = env_ff;
      rise_in      = rise_ff;
      acc_in       = acc_ff;
      sel_in       = sel_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      lga_in       = lga_ff;
      lgb_in       = lgb_ff;
      e_in         = e_ff;
      y_in         = y_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      j_in         = j_ff;
      gain_in      = gain_ff;
      out_s_in     = out_s_ff;
      out_g_in     = out_g_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      mul_a        = '0;
      mul_b        = '0;
      sum          = '0;
      env_new      = '0;
      sq           = '0;
      frac_new     = '0;
      trial        = '0;
      n_sh         = '0;
      y_sh         = '0;
      g_r          = '0;
      pm           = '0;
      t            = '0;
      q            = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               s_in     = req_chan.sample_in;
               state_in = ST_ENV_A;
            end
         end
         ST_ENV_A: begin
            mul_a    = MUL_W'(env_ff);
            mul_b    = MUL_W'(17'h10000 - {1'b0, rel_ff});
            acc_in   = prod[AW-1:0];
            rise_in  = (mag > env_ff) ? (mag - env_ff) : '0;
            state_in = ST_ENV_B;
         end
         ST_ENV_B: begin
            mul_a    = MUL_W'(att_ff);
            mul_b    = MUL_W'(rise_ff);
            sum      = acc_ff + prod[AW-1:0] + AW'(32768);
            env_new  = sum[AW-1:16];
            env_in   = (env_new > (EW+2)'(SMAX)) ? SMAX : env_new[EW-1:0];
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (VW'(env_ff) > VW'(thr_eff)) begin
               sel_in   = 1'b0;
               state_in = ST_LOG_INIT;
            end else begin
               gain_in  = {GAIN_W{1'b1}};
               state_in = ST_OUT;
            end
         end
         ST_LOG_INIT: begin
            p_in     = lead;
            m_in     = 31'(lv) << (5'd30 - lead);
            frac_in  = '0;
            cnt_in   = '0;
            state_in = ST_LOG_SQ;
         end
         ST_LOG_SQ: begin
            // mantissa stays in [1,2) as Q1.30
            mul_a    = MUL_W'(m_ff);
            mul_b    = MUL_W'(m_ff);
            sq       = prod[61:30];
            frac_new = {frac_ff[F-2:0], sq[31]};
            m_in     = sq[31] ? sq[31:1] : sq[30:0];
            frac_in  = frac_new;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == 5'(F-1)) begin
               if (!sel_ff) begin
                  lga_in   = {p_ff, frac_new};
                  sel_in   = 1'b1;
                  state_in = ST_LOG_INIT;
               end else begin
                  lgb_in   = {p_ff, frac_new};
                  state_in = ST_EXPO;
               end
            end
         end
         ST_EXPO: begin
            mul_a    = MUL_W'(slope_ff);
            mul_b    = MUL_W'(lga_ff - lgb_ff);
            e_in     = prod[XW-1:0];
            y_in     = 31'h4000_0000;
            cnt_in   = '0;
            state_in = ST_SQ_INIT;
         end
         ST_SQ_INIT: begin
            v_in     = e_ff[12 + cnt_ff] ? {1'b0, y_ff, 29'b0} : {y_ff, 30'b0};
            r_in     = '0;
            j_in     = 5'd30;
            state_in = ST_SQ_STEP;
         end
         ST_SQ_STEP: begin
            // one root bit per cycle, MSB first
            trial = r_ff | (31'd1 << j_ff);
            mul_a = MUL_W'(trial);
            mul_b = MUL_W'(trial);
            if (prod <= mul_product_type'(v_ff)) r_in = trial;
            j_in = j_ff - 1'b1;
            if (j_ff == '0) begin
               y_in   = (prod <= mul_product_type'(v_ff)) ? trial : r_ff;
               cnt_in = cnt_ff + 1'b1;
               state_in = (cnt_ff == 5'(F-1)) ? ST_SHIFT : ST_SQ_INIT;
            end
         end
         ST_SHIFT: begin
            n_sh     = e_ff[XW-1:F+12];
            y_sh     = (n_sh >= NW'(31)) ? '0 : (y_ff >> n_sh);
            g_r      = 17'((32'(y_sh) + 32'd16384) >> 15);
            gain_in  = (g_r > 17'd32767) ? {GAIN_W{1'b1}} : g_r[GAIN_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            mul_a = MUL_W'(abs_s);
            mul_b = MUL_W'(gain_ff);
            pm    = (SW+16)'($signed({1'b0, prod[SW+14:0]}));
            if (s_ff[SW-1]) pm = -pm;
            t     = pm + (SW+16)'(16384);
            q     = t[SW+15:15];
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (!q[SW] && q[SW-1])      out_s_in = {1'b0, {(SW-1){1'b1}}};
               else if (q[SW] && !q[SW-1]) out_s_in = {1'b1, {(SW-1){1'b0}}};
               else                        out_s_in = q[SW-1:0];
               out_g_in     = gain_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= 15'd32767;
         att_ff       <= 16'd41366;
         rel_ff       <= 16'd50;
         slope_ff     <= 16'd4096;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_THRESHOLD: thr_ff   <= csr_chan.wdata[14:0];
               CSR_ATTACK:    att_ff   <= csr_chan.wdata;
               CSR_RELEASE:   rel_ff   <= csr_chan.wdata;
               CSR_SLOPE:     slope_ff <= csr_chan.wdata;
               default: ;
            endcase
         end
      end
      s_ff     <= s_in;
      rise_ff  <= rise_in;
      acc_ff   <= acc_in;
      sel_ff   <= sel_in;
      p_ff     <= p_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      cnt_ff   <= cnt_in;
      lga_ff   <= lga_in;
      lgb_ff   <= lgb_in;
      e_ff     <= e_in;
      y_ff     <= y_in;
      v_ff     <= v_in;
      r_ff     <= r_in;
      j_ff     <= j_in;
      gain_ff  <= gain_in;
      out_s_ff <= out_s_in;
      out_g_ff <= out_g_in;
   end

endmodule
